// ----- hdl/ersa_pkg.sv -----
// ----------------------------------------------------------------------------
// ersa_pkg
// Shared types, codes and widths of the edge restriction scatter-add core.
// ----------------------------------------------------------------------------
`default_nettype none

package ersa_pkg;

  // Field widths
  localparam int NODE_W    = 12;
  localparam int COMP_W    = 2;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int NCOUNT_W  = 13;
  localparam int NCOMP_W   = 3;
  localparam int CFG_IDX_W = 1;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS   = OP_W + 2 * NODE_W + COMP_W + VALUE_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = VALUE_W + STATUS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Parameter defaults
  localparam int DEF_MAX_NODES      = 4096;
  localparam int DEF_MAX_COMPONENTS = 4;

  // Register reset values
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = NCOUNT_W'(4096);
  localparam logic [NCOMP_W-1:0]  COMPONENTS_RST = NCOMP_W'(1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 1'b1;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EDGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd3;

  // What the back end has to do with a classified request
  typedef enum logic [2:0] {
    K_WRITE,
    K_ADD,
    K_EDGE,
    K_READ,
    K_DONE
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [STATUS_W-1:0]  status;
    logic [NODE_W-1:0]    node;
    logic [NODE_W-1:0]    nbr;
    logic [COMP_W-1:0]    comp;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/ersa_front.sv -----
// ----------------------------------------------------------------------------
// ersa_front
// Holds the configuration registers and classifies incoming requests:
// range check, edge order check, halving of edge values.
// ----------------------------------------------------------------------------
`default_nettype none

module ersa_front #(
  parameter int MAX_NODES      = ersa_pkg::DEF_MAX_NODES,
  parameter int MAX_COMPONENTS = ersa_pkg::DEF_MAX_COMPONENTS
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  input  wire  [ersa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [ersa_pkg::NCOUNT_W-1:0]      cfg_data_i,
  input  wire  [ersa_pkg::OP_W-1:0]          op_i,
  input  wire  [ersa_pkg::NODE_W-1:0]        node_i,
  input  wire  [ersa_pkg::NODE_W-1:0]        nbr_i,
  input  wire  [ersa_pkg::COMP_W-1:0]        comp_i,
  input  wire  [ersa_pkg::VALUE_W-1:0]       value_i,
  output ersa_pkg::cmd_t                     cmd_o
);

  logic [ersa_pkg::NCOUNT_W-1:0] node_count_q;
  logic [ersa_pkg::NCOMP_W-1:0]  components_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= ersa_pkg::NODE_COUNT_RST;
      components_q <= ersa_pkg::COMPONENTS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ersa_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        ersa_pkg::CFG_COMPONENTS: components_q <= cfg_data_i[ersa_pkg::NCOMP_W-1:0];
        default: ;
      endcase
    end
  end

  logic node_ok, nbr_ok, comp_ok, range_bad, is_edge;

  // Effective limits are the smaller of register and build size
  assign node_ok = (ersa_pkg::NCOUNT_W'(node_i) < node_count_q) &&
                   (32'(node_i) < MAX_NODES);
  assign nbr_ok  = (ersa_pkg::NCOUNT_W'(nbr_i) < node_count_q) &&
                   (32'(nbr_i) < MAX_NODES);
  assign comp_ok = (ersa_pkg::NCOMP_W'(comp_i) < components_q) &&
                   (32'(comp_i) < MAX_COMPONENTS);
  assign is_edge = (op_i == ersa_pkg::OP_EDGE);
  assign range_bad = !node_ok || !comp_ok || (is_edge && !nbr_ok);

  always_comb begin
    cmd_o.node   = node_i;
    cmd_o.nbr    = nbr_i;
    cmd_o.comp   = comp_i;
    cmd_o.status = ersa_pkg::ST_OK;
    // Half of an edge value: arithmetic shift, rounds toward minus infinity
    cmd_o.value  = is_edge ? {value_i[ersa_pkg::VALUE_W-1], value_i[ersa_pkg::VALUE_W-1:1]}
                           : value_i;
    cmd_o.kind   = ersa_pkg::K_DONE;
    if (range_bad) begin
      cmd_o.status = ersa_pkg::ST_RANGE;
    end else if (is_edge && (node_i >= nbr_i)) begin
      cmd_o.status = ersa_pkg::ST_EDGE;
    end else begin
      unique case (op_i)
        ersa_pkg::OP_WRITE: cmd_o.kind = ersa_pkg::K_WRITE;
        ersa_pkg::OP_ADD:   cmd_o.kind = ersa_pkg::K_ADD;
        ersa_pkg::OP_EDGE:  cmd_o.kind = ersa_pkg::K_EDGE;
        ersa_pkg::OP_READ:  cmd_o.kind = ersa_pkg::K_READ;
        default:            cmd_o.kind = ersa_pkg::K_DONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ersa_queue.sv -----
// ----------------------------------------------------------------------------
// ersa_queue
// Two-entry request queue between the classifier and the executing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ersa_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_valid_i,
  output logic            push_ready_o,
  input  ersa_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  wire             pop_ready_i,
  output ersa_pkg::cmd_t  pop_cmd_o
);

  ersa_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ersa_back.sv -----
// ----------------------------------------------------------------------------
// ersa_back
// Executes classified requests on the accumulator memory with saturating
// read-modify-write and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ersa_back #(
  parameter int MAX_NODES      = ersa_pkg::DEF_MAX_NODES,
  parameter int MAX_COMPONENTS = ersa_pkg::DEF_MAX_COMPONENTS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cmd_valid_i,
  output logic                                 cmd_ready_o,
  input  ersa_pkg::cmd_t                       cmd_i,
  output logic                                 res_valid_o,
  input  wire                                  res_ready_i,
  output logic [ersa_pkg::VALUE_W-1:0]         read_value_o,
  output logic [ersa_pkg::STATUS_W-1:0]        status_o
);

  // Only rows reachable by a 12-bit node index are built
  localparam int ROWS  = (MAX_NODES < (1 << ersa_pkg::NODE_W)) ? MAX_NODES
                                                               : (1 << ersa_pkg::NODE_W);
  localparam int DEPTH = ROWS * MAX_COMPONENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW    = ersa_pkg::VALUE_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_EDGE2 = 2'd2;

  logic [1:0]     state_q, state_d;
  ersa_pkg::cmd_t cmd_q;
  logic           sat1_q, sat1_d;

  logic [VW-1:0]  mem [DEPTH];
  logic [VW-1:0]  rdata_q;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [VW-1:0]  wdata;

  logic [AW-1:0]  addr1_in, addr1, addr2;

  assign addr1_in = AW'(32'(cmd_i.node) * MAX_COMPONENTS + 32'(cmd_i.comp));
  assign addr1    = AW'(32'(cmd_q.node) * MAX_COMPONENTS + 32'(cmd_q.comp));
  assign addr2    = AW'(32'(cmd_q.nbr)  * MAX_COMPONENTS + 32'(cmd_q.comp));

  // Saturating add of the stored entry and the request value
  logic [VW:0]    sum_wide;
  logic [VW-1:0]  sum_sat;
  logic           sum_clamped;

  assign sum_wide    = {rdata_q[VW-1], rdata_q} + {cmd_q.value[VW-1], cmd_q.value};
  assign sum_clamped = (sum_wide[VW] != sum_wide[VW-1]);
  assign sum_sat     = !sum_clamped ? sum_wide[VW-1:0]
                     : (sum_wide[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Result register
  logic                          res_valid_q, res_load;
  logic [VW-1:0]                 read_value_q, read_value_d;
  logic [ersa_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          res_free;

  assign res_free     = !res_valid_q || res_ready_i;
  assign res_valid_o  = res_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;

  always_comb begin
    state_d      = state_q;
    sat1_d       = sat1_q;
    cmd_ready_o  = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = addr1_in;
    wr_en        = 1'b0;
    wr_addr      = addr1;
    wdata        = sum_sat;
    res_load     = 1'b0;
    read_value_d = '0;
    status_d     = ersa_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          rd_en   = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q.kind == ersa_pkg::K_EDGE) begin
          // First end: write back, fetch the second end
          wr_en   = 1'b1;
          sat1_d  = sum_clamped;
          rd_en   = 1'b1;
          rd_addr = addr2;
          state_d = S_EDGE2;
        end else if (res_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          case (cmd_q.kind)
            ersa_pkg::K_WRITE: begin
              wr_en = 1'b1;
              wdata = cmd_q.value;
            end
            ersa_pkg::K_ADD: begin
              wr_en    = 1'b1;
              status_d = sum_clamped ? ersa_pkg::ST_SAT : ersa_pkg::ST_OK;
            end
            ersa_pkg::K_READ: read_value_d = rdata_q;
            default:          status_d = cmd_q.status;
          endcase
        end
      end
      S_EDGE2: begin
        wr_addr = addr2;
        if (res_free) begin
          wr_en    = 1'b1;
          res_load = 1'b1;
          status_d = (sat1_q || sum_clamped) ? ersa_pkg::ST_SAT : ersa_pkg::ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (res_load) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sat1_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sat1_q  <= sat1_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/edge_restriction_scatter_add_core.sv -----
// Scatter-add accumulator for restricting a quadratic mesh vector onto its
// linear vertices, signed Q16.16 with saturation. The host writes every entry
// first, then streams vertex adds, edge adds (half the value to both ends,
// only when node < neighbor) and reads. Each request gives exactly one
// result. A classifier feeds a two-entry queue in front of the executing
// back end, which owns a single accumulator memory of
// min(MAX_NODES, 4096) * MAX_COMPONENTS entries with a registered read.
// A write, read, vertex add or rejected request takes the back end through S_IDLE
// and S_EXEC, an edge add also through S_EDGE2 (two read-modify-writes on that memory).
// Entries hold no reset value: read or add only entries that were written.
`default_nettype none

module edge_restriction_scatter_add_core #(
  parameter int MAX_NODES      = ersa_pkg::DEF_MAX_NODES,
  parameter int MAX_COMPONENTS = ersa_pkg::DEF_MAX_COMPONENTS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // op[1:0], node_index[13:2], neighbor_index[25:14], component[27:26],
  // value[59:28], zero pad
  input  wire  [ersa_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // read_value[31:0], status[33:32], zero pad
  output logic [ersa_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [ersa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [ersa_pkg::NCOUNT_W-1:0]        cfg_data_i
);

  localparam int NW = ersa_pkg::NODE_W;
  localparam int VW = ersa_pkg::VALUE_W;
  localparam int SW = ersa_pkg::STATUS_W;

  ersa_pkg::cmd_t front_cmd, back_cmd;
  logic           back_valid, back_ready;
  logic [VW-1:0]  read_value;
  logic [SW-1:0]  status;

  assign cfg_ready_o = 1'b1;

  ersa_front #(
    .MAX_NODES      (MAX_NODES),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (s_axis_tdata_i[1:0]),
    .node_i      (s_axis_tdata_i[2 +: NW]),
    .nbr_i       (s_axis_tdata_i[2 + NW +: NW]),
    .comp_i      (s_axis_tdata_i[2 + 2 * NW +: ersa_pkg::COMP_W]),
    .value_i     (s_axis_tdata_i[2 + 2 * NW + ersa_pkg::COMP_W +: VW]),
    .cmd_o       (front_cmd)
  );

  ersa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_ready_o (s_axis_tready_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  ersa_back #(
    .MAX_NODES      (MAX_NODES),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (back_valid),
    .cmd_ready_o  (back_ready),
    .cmd_i        (back_cmd),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .read_value_o (read_value),
    .status_o     (status)
  );

  assign m_axis_tdata_o = {{(ersa_pkg::OUT_DATA_W - ersa_pkg::OUT_BITS){1'b0}},
                           status, read_value};

endmodule

`default_nettype wire
